### rtl/core/bsig_pkg.sv
package bsig_pkg;

  // Number of fraction bits of every Q-format value at the ports.
  localparam int unsigned FRAC_BITS = 16;

  // Index of the last term of the alternating series for exp(-f), f in [0, 1).
  localparam int unsigned EXP_TERMS = 20;
  // Whole-number part at or above which exp(-|x|) is taken as zero.
  localparam int unsigned EXP_CUTOFF = 32;
  // Multiplications by exp(-1) needed for the largest whole part below the cutoff.
  localparam int unsigned POW_STEPS = EXP_CUTOFF - 1;
  // Quotient bits of p = e / (1 + e), which never exceeds one half.
  localparam int unsigned QUO_BITS = 31;

  localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
  localparam logic [63:0] ONE_Q31 = 64'd1 << 31;
  localparam logic [63:0] HALF_Q31 = 64'd1 << 30;

  // exp(-1) in Q0.32, formed as the square of the truncated series for exp(-1/2).
  localparam logic [32:0] EXP_NEG_ONE = 33'd1580030168;

  // The series term that leaves the last cell is subtracted when its index is odd.
  localparam logic LAST_TERM_SUB = 1'(EXP_TERMS % 2);

  // Configuration register indexes.
  localparam logic CFG_UPPER = 1'b0;
  localparam logic CFG_LOWER = 1'b1;

  typedef struct packed {
    logic signed [31:0] multiplier;
    logic               last_in;
  } bsig_in_t;

  typedef struct packed {
    logic signed [31:0] bounded_value;
    logic signed [31:0] slope;
    logic               last_out;
  } bsig_out_t;

  // Control that travels with every pipeline slot.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       pos;
    logic       big;
    logic [4:0] n;
  } ctl_t;

endpackage

### rtl/core/bsig_series_cell.sv
module bsig_series_cell
  import bsig_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        sub_i,
  input  logic [32:0] recip_i,
  input  logic [5:0]  shift_i,
  input  ctl_t        ctl_i,
  input  logic [31:0] frac_i,
  input  logic [32:0] term_i,
  input  logic [32:0] sum_i,
  output ctl_t        ctl_o,
  output logic [31:0] frac_o,
  output logic [32:0] term_o,
  output logic [32:0] sum_o
);

  ctl_t        ctl_a_q, ctl_b_q;
  logic [31:0] frac_a_q, frac_b_q;
  logic [31:0] v_a_q;
  logic [32:0] sum_a_d, sum_a_q, sum_b_q;
  logic [32:0] term_b_d, term_b_q;
  logic [64:0] prod;
  logic [64:0] quo_full;

  // First half: next raw term and folding the incoming term into the sum.
  assign prod    = 65'(term_i) * 65'(frac_i);
  assign sum_a_d = sub_i ? (sum_i - term_i) : (sum_i + term_i);

  // Second half: exact division by the term index through its reciprocal.
  assign quo_full = 65'(v_a_q) * 65'(recip_i);
  assign term_b_d = 33'(quo_full >> shift_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frac_a_q <= frac_i;
      v_a_q    <= prod[63:32];
      sum_a_q  <= sum_a_d;
      frac_b_q <= frac_a_q;
      term_b_q <= term_b_d;
      sum_b_q  <= sum_a_q;
    end
  end

  assign ctl_o  = ctl_b_q;
  assign frac_o = frac_b_q;
  assign term_o = term_b_q;
  assign sum_o  = sum_b_q;

endmodule

### rtl/core/bsig_pow_cell.sv
module bsig_pow_cell
  import bsig_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [4:0]  step_i,
  input  ctl_t        ctl_i,
  input  logic [32:0] e_i,
  output ctl_t        ctl_o,
  output logic [32:0] e_o
);

  ctl_t        ctl_q;
  logic [32:0] e_d, e_q;
  logic [64:0] prod;

  // Multiply by exp(-1) only while this step lies below the whole-number part.
  assign prod = 65'(e_i) * 65'(EXP_NEG_ONE);
  assign e_d  = (step_i < ctl_i.n) ? prod[64:32] : e_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= e_d;
    end
  end

  assign ctl_o = ctl_q;
  assign e_o   = e_q;

endmodule

### rtl/core/bsig_div_cell.sv
module bsig_div_cell
  import bsig_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ctl_t                ctl_i,
  input  logic [33:0]         rem_i,
  input  logic [33:0]         den_i,
  input  logic [QUO_BITS-1:0] quo_i,
  output ctl_t                ctl_o,
  output logic [33:0]         rem_o,
  output logic [33:0]         den_o,
  output logic [QUO_BITS-1:0] quo_o
);

  ctl_t                ctl_q;
  logic [34:0]         shifted;
  logic [34:0]         diff;
  logic                ge;
  logic [33:0]         rem_d, rem_q, den_q;
  logic [QUO_BITS-1:0] quo_q;

  // One restoring step: the remainder stays below the divisor.
  assign shifted = {rem_i, 1'b0};
  assign diff    = shifted - {1'b0, den_i};
  assign ge      = (shifted >= {1'b0, den_i});
  assign rem_d   = ge ? diff[33:0] : shifted[33:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= {quo_i[QUO_BITS-2:0], ge};
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

### rtl/core/bounded_sigmoid_with_slope_unit.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i  (bsig_in_t)
// out       output     out_valid_o / out_ready_i  out_data_o (bsig_out_t)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One transaction is taken per cycle while in_ready_o is high.
// The chain holds 40 series stages, 31 power stages, 31 divider stages and six
// stages of front, multiply and saturation logic, plus the output register.
// rst_ni clears all valid flags and loads upper_bound = 1.0, lower_bound = 0.0.
// A stalled output parks one result in a skid register; only when that register
// is full does the whole chain hold and in_ready_o fall.
module bounded_sigmoid_with_slope_unit
  import bsig_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bsig_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bsig_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // Saturate a signed 35-bit sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [31:0] upper_q, lower_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 32'd65536;
      lower_q <= 32'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_UPPER) begin
        upper_q <= cfg_data_i;
      end else begin
        lower_q <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: every stage moves together unless the skid register holds data.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_valid_d, skid_valid_q;
  logic out_valid_d, out_valid_q;
  bsig_out_t skid_data_d, skid_data_q;
  bsig_out_t out_data_d, out_data_q;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  // ---------------------------------------------------------------------------
  // Front stage: magnitude, whole part and fraction of the input.
  // ---------------------------------------------------------------------------
  logic [31:0] x_u, a;
  ctl_t        s0_ctl_d, s0_ctl_q;
  logic [31:0] s0_frac_d, s0_frac_q;

  assign x_u = in_data_i.multiplier;
  assign a   = x_u[31] ? (~x_u + 32'd1) : x_u;

  always_comb begin
    s0_ctl_d.valid = in_valid_i;
    s0_ctl_d.last  = in_data_i.last_in;
    s0_ctl_d.pos   = !x_u[31] && (x_u != 32'd0);
    // Any set bit above the low five bits of the whole part means a magnitude of 32 or more.
    s0_ctl_d.big   = |a[31:FRAC_BITS+5];
    s0_ctl_d.n     = a[FRAC_BITS+4:FRAC_BITS];
    s0_frac_d      = {a[FRAC_BITS-1:0], {(32-FRAC_BITS){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else if (en) begin
      s0_ctl_q <= s0_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_frac_q <= s0_frac_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Series for exp(-f): one cell per term after the leading 1.0, two stages each.
  // The sum starts at zero and the first cell folds in the leading term 1.0.
  // ---------------------------------------------------------------------------
  ctl_t        ser_ctl  [EXP_TERMS+1];
  logic [31:0] ser_frac [EXP_TERMS+1];
  logic [32:0] ser_term [EXP_TERMS+1];
  logic [32:0] ser_sum  [EXP_TERMS+1];

  assign ser_ctl[0]  = s0_ctl_q;
  assign ser_frac[0] = s0_frac_q;
  assign ser_term[0] = ONE_Q32[32:0];
  assign ser_sum[0]  = 33'd0;

  for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_series
    // Division by k as a multiplication that is exact for any 32-bit dividend.
    localparam int unsigned Lg     = $clog2(k);
    localparam logic [5:0]  Shift  = 6'(32 + Lg);
    localparam logic [32:0] Recip  = 33'(((64'd1 << (32 + Lg)) + 64'(k) - 64'd1) / 64'(k));
    localparam logic        SubIn  = 1'((k - 1) % 2);

    bsig_series_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .sub_i   (SubIn),
      .recip_i (Recip),
      .shift_i (Shift),
      .ctl_i   (ser_ctl[k-1]),
      .frac_i  (ser_frac[k-1]),
      .term_i  (ser_term[k-1]),
      .sum_i   (ser_sum[k-1]),
      .ctl_o   (ser_ctl[k]),
      .frac_o  (ser_frac[k]),
      .term_o  (ser_term[k]),
      .sum_o   (ser_sum[k])
    );
  end

  // The last term is folded in here; large magnitudes force the exponential to zero.
  ctl_t        s1_ctl_q;
  logic [32:0] s1_e_d, s1_e_q;

  always_comb begin
    s1_e_d = LAST_TERM_SUB ? (ser_sum[EXP_TERMS] - ser_term[EXP_TERMS])
                           : (ser_sum[EXP_TERMS] + ser_term[EXP_TERMS]);
    if (ser_ctl[EXP_TERMS].big) begin
      s1_e_d = 33'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else if (en) begin
      s1_ctl_q <= ser_ctl[EXP_TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_e_q <= s1_e_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Whole part: multiply by exp(-1) once per unit of the magnitude.
  // ---------------------------------------------------------------------------
  ctl_t        pow_ctl [POW_STEPS+1];
  logic [32:0] pow_e   [POW_STEPS+1];

  assign pow_ctl[0] = s1_ctl_q;
  assign pow_e[0]   = s1_e_q;

  for (genvar i = 0; i < POW_STEPS; i++) begin : g_pow
    bsig_pow_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (5'(i)),
      .ctl_i  (pow_ctl[i]),
      .e_i    (pow_e[i]),
      .ctl_o  (pow_ctl[i+1]),
      .e_o    (pow_e[i+1])
    );
  end

  // Divider set-up: p = (e << 31) / (1 + e); the first remainder is e itself.
  ctl_t        s2_ctl_q;
  logic [33:0] s2_rem_q, s2_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (en) begin
      s2_ctl_q <= pow_ctl[POW_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_rem_q <= 34'(pow_e[POW_STEPS]);
      s2_den_q <= ONE_Q32[33:0] + 34'(pow_e[POW_STEPS]);
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: one quotient bit per cell.
  // ---------------------------------------------------------------------------
  ctl_t                div_ctl [QUO_BITS+1];
  logic [33:0]         div_rem [QUO_BITS+1];
  logic [33:0]         div_den [QUO_BITS+1];
  logic [QUO_BITS-1:0] div_quo [QUO_BITS+1];

  assign div_ctl[0] = s2_ctl_q;
  assign div_rem[0] = s2_rem_q;
  assign div_den[0] = s2_den_q;
  assign div_quo[0] = '0;

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    bsig_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (div_ctl[j]),
      .rem_i  (div_rem[j]),
      .den_i  (div_den[j]),
      .quo_i  (div_quo[j]),
      .ctl_o  (div_ctl[j+1]),
      .rem_o  (div_rem[j+1]),
      .den_o  (div_den[j+1]),
      .quo_o  (div_quo[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Sigmoid s and s*(1-s), both Q0.31.
  // ---------------------------------------------------------------------------
  logic [QUO_BITS-1:0] p;
  logic [31:0]         comp;
  logic [62:0]         pt_prod;
  logic [63:0]         pt_rnd;
  ctl_t                s3_ctl_q;
  logic [31:0]         s3_s_q, s3_t_q;

  assign p       = div_quo[QUO_BITS];
  assign comp    = ONE_Q31[31:0] - 32'(p);
  assign pt_prod = 63'(p) * 63'(comp);
  assign pt_rnd  = 64'(pt_prod) + HALF_Q31;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q <= '0;
    end else if (en) begin
      s3_ctl_q <= div_ctl[QUO_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_s_q <= div_ctl[QUO_BITS].pos ? comp : 32'(p);
      s3_t_q <= pt_rnd[62:31];
    end
  end

  // ---------------------------------------------------------------------------
  // Scale by the span between the bounds, on its magnitude.
  // ---------------------------------------------------------------------------
  logic [32:0] span, span_mag;
  ctl_t        s4_ctl_q;
  logic        s4_neg_q;
  logic [63:0] s4_ps_q, s4_pt_q;
  logic [64:0] ps_full, pt_full;

  assign span     = {upper_q[31], upper_q} - {lower_q[31], lower_q};
  assign span_mag = span[32] ? (~span + 33'd1) : span;
  assign ps_full  = 65'(span_mag) * 65'(s3_s_q);
  assign pt_full  = 65'(span_mag) * 65'(s3_t_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_ctl_q <= '0;
    end else if (en) begin
      s4_ctl_q <= s3_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_neg_q <= span[32];
      s4_ps_q  <= ps_full[63:0];
      s4_pt_q  <= pt_full[63:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Round half away from zero, restore sign, add the lower bound, saturate.
  // ---------------------------------------------------------------------------
  logic [63:0]        rs_sum, rt_sum;
  logic signed [34:0] rs, rt, val_sum;
  ctl_t               fin_ctl_q;
  bsig_out_t          fin_d, fin_q;

  always_comb begin
    rs_sum  = s4_ps_q + HALF_Q31;
    rt_sum  = s4_pt_q + HALF_Q31;
    rs      = $signed({2'b00, rs_sum[63:31]});
    rt      = $signed({2'b00, rt_sum[63:31]});
    if (s4_neg_q) begin
      rs = -rs;
      rt = -rt;
    end
    val_sum             = $signed({{3{lower_q[31]}}, lower_q}) + rs;
    fin_d.bounded_value = sat32(val_sum);
    fin_d.slope         = sat32(rt);
    fin_d.last_out      = s4_ctl_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_ctl_q <= '0;
    end else if (en) begin
      fin_ctl_q <= s4_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid slot behind it.
  // ---------------------------------------------------------------------------
  logic take, out_fire;

  assign take     = en && fin_ctl_q.valid;
  assign out_fire = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (take) begin
      if (!out_valid_q || out_fire) begin
        out_data_d  = fin_q;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = fin_q;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a transaction while the output register is empty");

  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_ctl_q.valid |-> (s1_e_q <= ONE_Q32[32:0]))
    else $error("series result exceeds one");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl[QUO_BITS].valid |-> (64'(div_quo[QUO_BITS]) <= HALF_Q31))
    else $error("divider quotient exceeds one half");

  a_big_is_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_ctl[QUO_BITS].valid && div_ctl[QUO_BITS].big) |-> (div_quo[QUO_BITS] == '0))
    else $error("large magnitude did not give a flat sigmoid");
`endif

endmodule
